/* src/bcl_pkg.sv */
// Shared constants, types and the microcode table of the biquad cascade low-pass unit.
package bcl_pkg;

	localparam int DEF_STAGES      = 3;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_COEF_BITS   = 20;

	localparam int NUM_REGS      = 5;
	localparam int REG_IDX_BITS  = 3;
	localparam int STEPS         = 6;
	localparam int STEP_BITS     = 3;
	localparam int ACC_GUARD     = 3;

	// Operand / coefficient select; the code doubles as the register index.
	typedef enum logic [REG_IDX_BITS-1:0] {
		SRC_X  = 3'd0,
		SRC_X1 = 3'd1,
		SRC_X2 = 3'd2,
		SRC_Y1 = 3'd3,
		SRC_Y2 = 3'd4
	} src_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		src_t    src;
		acc_op_t acc_op;
		logic    fin;
	} ucode_t;

	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(STEPS - 1);

	// One control word per step of a section.
	function automatic ucode_t ucode(input logic [STEP_BITS-1:0] step);
		ucode_t w;
		w = '{mul_en: 1'b0, src: SRC_X, acc_op: ACC_HOLD, fin: 1'b0};
		unique case (step)
			3'd0: w = '{mul_en: 1'b1, src: SRC_X,  acc_op: ACC_HOLD, fin: 1'b0};
			3'd1: w = '{mul_en: 1'b1, src: SRC_X1, acc_op: ACC_LOAD, fin: 1'b0};
			3'd2: w = '{mul_en: 1'b1, src: SRC_X2, acc_op: ACC_ADD,  fin: 1'b0};
			3'd3: w = '{mul_en: 1'b1, src: SRC_Y1, acc_op: ACC_ADD,  fin: 1'b0};
			3'd4: w = '{mul_en: 1'b1, src: SRC_Y2, acc_op: ACC_SUB,  fin: 1'b0};
			3'd5: w = '{mul_en: 1'b0, src: SRC_X,  acc_op: ACC_SUB,  fin: 1'b1};
			default: w = '{mul_en: 1'b0, src: SRC_X, acc_op: ACC_HOLD, fin: 1'b0};
		endcase
		return w;
	endfunction

endpackage

/* src/biquad_cascade_lowpass_unit.sv */
// Top level of the biquad cascade low-pass unit: sequencer, MAC datapath and registers.
//
// Usage:
//   Input channel (in_valid / in_ready / sample_in) takes one signed sample per
//   transaction; the output channel (out_valid / out_ready / sample_out) returns
//   one filtered, saturated sample per input, in order.
//   The cfg port (cfg_write / cfg_index / cfg_data) writes a coefficient register:
//   0 b0, 1 b1, 2 b2, 3 a1, 4 a2, STAGES fields of COEF_BITS each,
//   stage 0 in the low bits. Other indexes are dropped. Write only while idle.
// Sequencing:
//   One shared multiplier and accumulator run a six-step microprogram per
//   section and step through every section in turn from acceptance to out_valid;
//   in_ready stays low until the sequencer finishes and rises the cycle after,
//   so the unit takes no new sample while one is still running. The
//   multiply-accumulate loop through the single multiplier sets this pace.
// Reset: all delay lines clear to zero, b0 resets to 1.0 per stage and the other
//   coefficients to zero, so the unit passes samples through unchanged.
// Stall: the result register holds until taken; a new item may be accepted and
//   run meanwhile, and its final step waits while a full result register is not taken.
module biquad_cascade_lowpass_unit #(
	parameter int STAGES      = bcl_pkg::DEF_STAGES,
	parameter int SAMPLE_BITS = bcl_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = bcl_pkg::DEF_COEF_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [bcl_pkg::REG_IDX_BITS-1:0]     cfg_index,
	input  logic [STAGES*COEF_BITS-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        sample_out
);

	localparam int CFG_BITS  = STAGES * COEF_BITS;
	localparam int STG_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS  = PROD_BITS + bcl_pkg::ACC_GUARD;
	localparam int FRAC      = COEF_BITS - 3;

	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << FRAC;
	localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (FRAC - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_HI = (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - 1;
	localparam logic [STG_W-1:0] STAGE_LAST = STG_W'(STAGES - 1);

	// Coefficient registers
	logic [CFG_BITS-1:0] coef_q [bcl_pkg::NUM_REGS];

	// Per-section delay lines
	logic signed [SAMPLE_BITS-1:0] x1_q [STAGES];
	logic signed [SAMPLE_BITS-1:0] x2_q [STAGES];
	logic signed [SAMPLE_BITS-1:0] y1_q [STAGES];
	logic signed [SAMPLE_BITS-1:0] y2_q [STAGES];

	// Sequencer and datapath
	logic                          busy_q;
	logic [bcl_pkg::STEP_BITS-1:0] step_q;
	logic [STG_W-1:0]              stage_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	bcl_pkg::ucode_t               uc;
	logic signed [SAMPLE_BITS-1:0] opnd;
	logic signed [COEF_BITS-1:0]   coef;
	logic signed [ACC_BITS-1:0]    prod_ext;
	logic signed [ACC_BITS-1:0]    sum;
	logic signed [ACC_BITS-1:0]    shifted;
	logic signed [SAMPLE_BITS-1:0] y;
	logic                          last_stage;
	logic                          stall;
	logic                          adv;
	logic                          in_acc;

	assign uc         = bcl_pkg::ucode(step_q);
	assign last_stage = (stage_q == STAGE_LAST);
	// Hold the last section's final step while the previous result is still waiting.
	assign stall      = uc.fin && last_stage && out_valid_q && !out_ready;
	assign adv        = busy_q && !stall;
	assign in_ready   = !busy_q;
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// Operand and coefficient select for the current step
	always_comb begin
		case (uc.src)
			bcl_pkg::SRC_X1: opnd = x1_q[stage_q];
			bcl_pkg::SRC_X2: opnd = x2_q[stage_q];
			bcl_pkg::SRC_Y1: opnd = y1_q[stage_q];
			bcl_pkg::SRC_Y2: opnd = y2_q[stage_q];
			default:         opnd = x_q;
		endcase
		coef = coef_q[uc.src][stage_q*COEF_BITS +: COEF_BITS];
	end

	// Accumulate, round half up, saturate
	always_comb begin
		prod_ext = ACC_BITS'(prod_q);
		case (uc.acc_op)
			bcl_pkg::ACC_LOAD: sum = ACC_HALF + prod_ext;
			bcl_pkg::ACC_ADD:  sum = acc_q + prod_ext;
			bcl_pkg::ACC_SUB:  sum = acc_q - prod_ext;
			default:           sum = acc_q;
		endcase
		shifted = sum >>> FRAC;
		if (shifted > SAT_HI) begin
			y = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			y = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y = shifted[SAMPLE_BITS-1:0];
		end
	end

	// Coefficient register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= {STAGES{COEF_ONE}};
			for (int r = 1; r < bcl_pkg::NUM_REGS; r++) begin
				coef_q[r] <= '0;
			end
		end else if (cfg_write && (cfg_index < bcl_pkg::REG_IDX_BITS'(bcl_pkg::NUM_REGS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Sequencer, delay lines and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < STAGES; s++) begin
				x1_q[s] <= '0;
				x2_q[s] <= '0;
				y1_q[s] <= '0;
				y2_q[s] <= '0;
			end
		end else begin
			// Load a new result, else drop the one just taken.
			if (adv && uc.fin && last_stage) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				busy_q  <= 1'b1;
				step_q  <= '0;
				stage_q <= '0;
			end else if (adv) begin
				if (uc.fin) begin
					// Close the section: shift delay lines, pass y on
					x1_q[stage_q] <= x_q;
					x2_q[stage_q] <= x1_q[stage_q];
					y1_q[stage_q] <= y;
					y2_q[stage_q] <= y1_q[stage_q];
					step_q        <= '0;
					if (last_stage) begin
						busy_q <= 1'b0;
					end else begin
						stage_q <= stage_q + STG_W'(1);
					end
				end else begin
					step_q <= step_q + bcl_pkg::STEP_BITS'(1);
				end
			end
		end
	end

	// Datapath registers (no reset needed)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_in;
		end else if (adv) begin
			if (uc.mul_en) begin
				prod_q <= PROD_BITS'(opnd * coef);
			end
			acc_q <= sum;
			if (uc.fin) begin
				x_q <= y;
				if (last_stage) begin
					sample_out_q <= y;
				end
			end
		end
	end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the three-stage biquad cascade low-pass unit.
`timescale 1ns / 100ps

module testbench;

	localparam int STAGE_COUNT = bcl_pkg::DEF_STAGES;
	localparam int SAMPLE_W    = bcl_pkg::DEF_SAMPLE_BITS;
	localparam int COEF_W      = bcl_pkg::DEF_COEF_BITS;
	localparam int CFG_W       = STAGE_COUNT * COEF_W;
	localparam int COEF_FRAC   = COEF_W - 3;
	localparam int IDX_W       = bcl_pkg::REG_IDX_BITS;

	localparam longint SAT_MAX    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAT_MIN    = -SAT_MAX - 1;
	localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);

	localparam int COEF_ONE  = 1 << COEF_FRAC;
	localparam int COEF_HALF = 1 << (COEF_W - 1);
	localparam int COEF_MAX  = COEF_HALF - 1;
	localparam int COEF_MIN  = -COEF_HALF;

	localparam logic [COEF_W-1:0] COEF_ONE_FIELD = COEF_W'(COEF_ONE);
	localparam logic [CFG_W-1:0]  UNITY_B0       = {STAGE_COUNT{COEF_ONE_FIELD}};

	// Butterworth sections at fs/8 (Q = 0.52, 0.71, 1.93), Q3.17
	localparam int LP_B0 [STAGE_COUNT] = '{11403, 12793, 16227};
	localparam int LP_B1 [STAGE_COUNT] = '{22806, 25586, 32454};
	localparam int LP_A1 [STAGE_COUNT] = '{-110127, -123573, -156684};
	localparam int LP_A2 [STAGE_COUNT] = '{24681, 43686, 90519};

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 116;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG      = 2000;
	localparam int REPORT_LIMIT  = 10;

	// Bit-exact model of the cascade with its own coefficient copy and delay lines.
	class cascade_scoreboard;
		logic [CFG_W-1:0] coef_reg [bcl_pkg::NUM_REGS];
		longint x_one [STAGE_COUNT];
		longint x_two [STAGE_COUNT];
		longint y_one [STAGE_COUNT];
		longint y_two [STAGE_COUNT];
		logic signed [SAMPLE_W-1:0] expected_samples [$];
		int mismatch_count;

		function new();
			mismatch_count = 0;
			foreach (coef_reg[i]) coef_reg[i] = '0;
			coef_reg[bcl_pkg::SRC_X] = UNITY_B0;
			for (int s = 0; s < STAGE_COUNT; s++) begin
				x_one[s] = 0;
				x_two[s] = 0;
				y_one[s] = 0;
				y_two[s] = 0;
			end
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx < bcl_pkg::NUM_REGS)
				coef_reg[idx] = value;
		endfunction

		function longint coef_of(bcl_pkg::src_t which, int stage);
			logic signed [COEF_W-1:0] field;
			field = coef_reg[int'(which)][stage*COEF_W +: COEF_W];
			return field;
		endfunction

		function logic signed [SAMPLE_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] sample);
			longint stage_in;
			longint acc;
			longint stage_out;
			stage_in = sample;
			for (int s = 0; s < STAGE_COUNT; s++) begin
				acc = coef_of(bcl_pkg::SRC_X, s) * stage_in
				    + coef_of(bcl_pkg::SRC_X1, s) * x_one[s]
				    + coef_of(bcl_pkg::SRC_X2, s) * x_two[s]
				    - coef_of(bcl_pkg::SRC_Y1, s) * y_one[s]
				    - coef_of(bcl_pkg::SRC_Y2, s) * y_two[s];
				stage_out = (acc + ROUND_HALF) >>> COEF_FRAC;
				if (stage_out > SAT_MAX)
					stage_out = SAT_MAX;
				else if (stage_out < SAT_MIN)
					stage_out = SAT_MIN;
				x_two[s] = x_one[s];
				x_one[s] = stage_in;
				y_two[s] = y_one[s];
				y_one[s] = stage_out;
				stage_in = stage_out;
			end
			return SAMPLE_W'(stage_in);
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] sample);
			expected_samples.push_back(filter_sample(sample));
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected output sample %0d", got);
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("sample_out mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write;
	logic [IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	cascade_scoreboard filter_sb;
	bit idling_on;
	int quiet_cycles;

	biquad_cascade_lowpass_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Pack one field per stage, stage 0 in the low bits.
	function automatic logic [CFG_W-1:0] pack_stages(int f0, int f1, int f2);
		return {COEF_W'(f2), COEF_W'(f1), COEF_W'(f0)};
	endfunction

	// Each stage gets an independent field drawn from [-half_span, half_span).
	function automatic logic [CFG_W-1:0] random_coefs(int half_span);
		return pack_stages($urandom_range(0, 2*half_span - 1) - half_span,
		                   $urandom_range(0, 2*half_span - 1) - half_span,
		                   $urandom_range(0, 2*half_span - 1) - half_span);
	endfunction

	// Small perturbation so the low-pass phases do not all run identical taps.
	function automatic int jitter();
		return $urandom_range(0, 64) - 32;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7)) inside
			0: return $urandom_range(0, 1) ? SAMPLE_W'(SAT_MAX) : SAMPLE_W'(SAT_MIN);
			[1:2]: return SAMPLE_W'($urandom_range(0, 8191) - 4096);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offer one sample, optionally after an idle burst, and hold it until taken.
	// Valid is left high on return; end_stream drops it once the phase is over.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		int gap;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (!in_ready);
		filter_sb.note_sample(value);
	endtask

	// Drop valid in the step of the last transaction and wait for every result.
	task automatic end_stream();
		in_valid <= 1'b0;
		while (filter_sb.pending() > 0) @(posedge clk);
	endtask

	// Write all five coefficient registers, then one stray index that must be dropped.
	// Write enable stays high across the burst so it is never dropped and raised in one step.
	task automatic apply_coefs(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
	                           input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
	                           input logic [CFG_W-1:0] a2);
		logic [CFG_W-1:0] vals [bcl_pkg::NUM_REGS];
		logic [IDX_W-1:0] stray;
		logic [CFG_W-1:0] junk;
		vals[bcl_pkg::SRC_X]  = b0;
		vals[bcl_pkg::SRC_X1] = b1;
		vals[bcl_pkg::SRC_X2] = b2;
		vals[bcl_pkg::SRC_Y1] = a1;
		vals[bcl_pkg::SRC_Y2] = a2;
		for (int i = 0; i < bcl_pkg::NUM_REGS; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			filter_sb.write_reg(IDX_W'(i), vals[i]);
		end
		stray = IDX_W'($urandom_range(bcl_pkg::NUM_REGS, (1 << IDX_W) - 1));
		junk  = CFG_W'({$urandom, $urandom});
		cfg_index <= stray;
		cfg_data  <= junk;
		@(posedge clk);
		filter_sb.write_reg(stray, junk);
		cfg_write <= 1'b0;
	endtask

	// Result side: random stall bursts while idling is on, otherwise always ready.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Check each result transaction; count cycles with no transaction on either side.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (out_valid && out_ready)
				filter_sb.check_sample(sample_out);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] pass_items [$];
		logic [CFG_W-1:0] all_max;
		logic [CFG_W-1:0] all_min;
		logic [CFG_W-1:0] all_neg_lsb;
		int phase;

		filter_sb    = new();
		idling_on    = 1'b0;
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample_in <= '0;

		// Hold reset, then release it for good.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on = 1'b1;

		// Reset coefficients: unity pass-through, so field extremes come straight back.
		pass_items = '{SAMPLE_W'(0), SAMPLE_W'(SAT_MAX), SAMPLE_W'(SAT_MIN), SAMPLE_W'(1),
		               SAMPLE_W'(-1), SAMPLE_W'('h555555), SAMPLE_W'('haaaaaa)};
		foreach (pass_items[i]) send_sample(pass_items[i]);
		end_stream();

		// Largest positive coefficient everywhere: overflow clamps at both rails.
		all_max = pack_stages(COEF_MAX, COEF_MAX, COEF_MAX);
		apply_coefs(all_max, all_max, all_max, all_max, all_max);
		pass_items = '{SAMPLE_W'(SAT_MAX), SAMPLE_W'(SAT_MIN), SAMPLE_W'(SAT_MIN), SAMPLE_W'(0)};
		foreach (pass_items[i]) send_sample(pass_items[i]);
		end_stream();

		// Most negative coefficient everywhere.
		all_min = pack_stages(COEF_MIN, COEF_MIN, COEF_MIN);
		apply_coefs(all_min, all_min, all_min, all_min, all_min);
		pass_items = '{SAMPLE_W'(SAT_MIN), SAMPLE_W'(SAT_MAX), SAMPLE_W'(1)};
		foreach (pass_items[i]) send_sample(pass_items[i]);
		end_stream();

		// One negative LSB everywhere: every coefficient bit set.
		all_neg_lsb = pack_stages(-1, -1, -1);
		apply_coefs(all_neg_lsb, all_neg_lsb, all_neg_lsb, all_neg_lsb, all_neg_lsb);
		pass_items = '{SAMPLE_W'(SAT_MAX), SAMPLE_W'(-1)};
		foreach (pass_items[i]) send_sample(pass_items[i]);
		end_stream();

		// Tiny stage-0 gain puts results on and beside the half-LSB boundary: ties round up.
		apply_coefs(pack_stages(1, COEF_ONE, COEF_ONE), '0, '0, '0, '0);
		pass_items = '{SAMPLE_W'(65536), SAMPLE_W'(-65536), SAMPLE_W'(65535),
		               SAMPLE_W'(-65537)};
		foreach (pass_items[i]) send_sample(pass_items[i]);
		end_stream();

		// All-zero coefficients mute the output.
		apply_coefs('0, '0, '0, '0, '0);
		send_sample(SAMPLE_W'(SAT_MAX));
		end_stream();

		// Random phases; the delay lines carry over between coefficient sets.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				idling_on = 1'b0;
			case (phase % 4)
				0: apply_coefs(pack_stages(LP_B0[0] + jitter(), LP_B0[1] + jitter(),
				                           LP_B0[2] + jitter()),
				               pack_stages(LP_B1[0] + jitter(), LP_B1[1] + jitter(),
				                           LP_B1[2] + jitter()),
				               pack_stages(LP_B0[0] + jitter(), LP_B0[1] + jitter(),
				                           LP_B0[2] + jitter()),
				               pack_stages(LP_A1[0] + jitter(), LP_A1[1] + jitter(),
				                           LP_A1[2] + jitter()),
				               pack_stages(LP_A2[0] + jitter(), LP_A2[1] + jitter(),
				                           LP_A2[2] + jitter()));
				1: apply_coefs(random_coefs(COEF_HALF), random_coefs(COEF_HALF),
				               random_coefs(COEF_HALF), random_coefs(COEF_HALF),
				               random_coefs(COEF_HALF));
				2: apply_coefs(random_coefs(1 << 15), random_coefs(1 << 15),
				               random_coefs(1 << 15), random_coefs(1 << 15),
				               random_coefs(1 << 15));
				default: apply_coefs(random_coefs(COEF_HALF), random_coefs(1 << 15),
				                     random_coefs(1 << 15), '0, '0);
			endcase
			repeat (PHASE_ITEMS) send_sample(random_sample());
			end_stream();
		end

		// Let any stray output show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (filter_sb.mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
